>>> src/btot_pkg.sv
// Shared constants for the box-triangle overlap test.
package btot_pkg;

  // Triangle geometry.
  localparam int NUM_VERTS = 3;
  localparam int NUM_EDGES = 3;

  // Vertex index type, wide enough for three vertices.
  typedef logic [1:0] vidx_t;

  // Edge k runs from vertex k to vertex NEXT_VERT[k].
  localparam vidx_t NEXT_VERT [NUM_EDGES] = '{2'd1, 2'd2, 2'd0};

  // The two triangle points projected onto the normal of edge k.
  localparam vidx_t EDGE_PT_A [NUM_EDGES] = '{2'd1, 2'd0, 2'd1};
  localparam vidx_t EDGE_PT_B [NUM_EDGES] = '{2'd2, 2'd1, 2'd2};

endpackage

>>> src/btot_if.sv
// Valid/ready channel interfaces for the box-triangle overlap test.
interface btot_in_if #(
  parameter int COORD_BITS = 16
);
  logic                         valid;
  logic                         ready;
  logic signed [COORD_BITS-1:0] box_min_x;
  logic signed [COORD_BITS-1:0] box_min_y;
  logic signed [COORD_BITS-1:0] box_max_x;
  logic signed [COORD_BITS-1:0] box_max_y;
  logic signed [COORD_BITS-1:0] vert0_x;
  logic signed [COORD_BITS-1:0] vert0_y;
  logic signed [COORD_BITS-1:0] vert1_x;
  logic signed [COORD_BITS-1:0] vert1_y;
  logic signed [COORD_BITS-1:0] vert2_x;
  logic signed [COORD_BITS-1:0] vert2_y;

  modport source (
    output valid, box_min_x, box_min_y, box_max_x, box_max_y,
           vert0_x, vert0_y, vert1_x, vert1_y, vert2_x, vert2_y,
    input  ready
  );

  modport sink (
    input  valid, box_min_x, box_min_y, box_max_x, box_max_y,
           vert0_x, vert0_y, vert1_x, vert1_y, vert2_x, vert2_y,
    output ready
  );
endinterface

interface btot_out_if;
  logic valid;
  logic ready;
  logic overlap;

  modport source (
    output valid, overlap,
    input  ready
  );

  modport sink (
    input  valid, overlap,
    output ready
  );
endinterface

>>> src/box_triangle_overlap_test.sv
// Box-triangle overlap test: five-stage separating-axis pipeline.
// A result becomes valid on out_if once its input has passed the stage 1 to 4 registers and the output register.
// Throughput: one item per cycle while out_if.ready is high; the stages advance independently, so bubbles are squeezed.
// The critical stage is the one with the projection multipliers (edge x point, |edge| x extent).
// Reset (rst_n low, synchronous) clears every stage valid bit; data registers are not reset.
module box_triangle_overlap_test
  import btot_pkg::*;
#(
  parameter int COORD_BITS = 16
) (
  input  logic         clk,
  input  logic         rst_n,
  btot_in_if.sink      in_if,
  btot_out_if.source   out_if
);

  // Doubled-scale widths: half extent, centered vertex, edge vector, product, projection.
  localparam int HW = COORD_BITS + 1;
  localparam int VW = COORD_BITS + 2;
  localparam int EW = COORD_BITS + 3;
  localparam int MW = EW + VW;
  localparam int PW = MW + 3;

  // Stage enables: a stage loads when it is empty or its successor loads.
  logic en1, en2, en3, en4, en_out;
  logic s1_valid_r, s2_valid_r, s3_valid_r, s4_valid_r, out_valid_r;

  assign en_out = !out_valid_r || out_if.ready;
  assign en4    = !s4_valid_r || en_out;
  assign en3    = !s3_valid_r || en4;
  assign en2    = !s2_valid_r || en3;
  assign en1    = !s1_valid_r || en2;

  assign in_if.ready = en1;

  // Valid bits travel with the data.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      s2_valid_r  <= 1'b0;
      s3_valid_r  <= 1'b0;
      s4_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (en1)    s1_valid_r  <= in_if.valid;
      if (en2)    s2_valid_r  <= s1_valid_r;
      if (en3)    s3_valid_r  <= s2_valid_r;
      if (en4)    s4_valid_r  <= s3_valid_r;
      if (en_out) out_valid_r <= s4_valid_r;
    end
  end

  // ---------------------------------------------------------------------
  // Stage 1: vertices relative to the doubled box center, doubled extents.
  // ---------------------------------------------------------------------
  logic signed [COORD_BITS-1:0] in_vx [NUM_VERTS];
  logic signed [COORD_BITS-1:0] in_vy [NUM_VERTS];
  logic signed [VW-1:0]         vx_nxt [NUM_VERTS];
  logic signed [VW-1:0]         vy_nxt [NUM_VERTS];
  logic signed [HW-1:0]         hx_nxt, hy_nxt;
  logic signed [VW-1:0]         s1_vx_r [NUM_VERTS];
  logic signed [VW-1:0]         s1_vy_r [NUM_VERTS];
  logic signed [HW-1:0]         s1_hx_r, s1_hy_r;

  assign in_vx[0] = in_if.vert0_x;
  assign in_vy[0] = in_if.vert0_y;
  assign in_vx[1] = in_if.vert1_x;
  assign in_vy[1] = in_if.vert1_y;
  assign in_vx[2] = in_if.vert2_x;
  assign in_vy[2] = in_if.vert2_y;

  always_comb begin
    for (int i = 0; i < NUM_VERTS; i++) begin
      vx_nxt[i] = (VW'(in_vx[i]) <<< 1) - VW'(in_if.box_min_x) - VW'(in_if.box_max_x);
      vy_nxt[i] = (VW'(in_vy[i]) <<< 1) - VW'(in_if.box_min_y) - VW'(in_if.box_max_y);
    end
    hx_nxt = HW'(in_if.box_max_x) - HW'(in_if.box_min_x);
    hy_nxt = HW'(in_if.box_max_y) - HW'(in_if.box_min_y);
  end

  always_ff @(posedge clk) begin
    if (en1 && in_if.valid) begin
      s1_vx_r <= vx_nxt;
      s1_vy_r <= vy_nxt;
      s1_hx_r <= hx_nxt;
      s1_hy_r <= hy_nxt;
    end
  end

  // ---------------------------------------------------------------------
  // Stage 2: edge vectors, their magnitudes and the two box-axis tests.
  // ---------------------------------------------------------------------
  logic signed [EW-1:0] ex_nxt [NUM_EDGES];
  logic signed [EW-1:0] ey_nxt [NUM_EDGES];
  logic        [EW-1:0] aex_nxt [NUM_EDGES];
  logic        [EW-1:0] aey_nxt [NUM_EDGES];
  logic signed [VW-1:0] hx_ext, hy_ext, nhx, nhy;
  logic                 above_x, below_x, above_y, below_y;
  logic                 sep_axis_nxt;

  logic signed [EW-1:0] s2_ex_r [NUM_EDGES];
  logic signed [EW-1:0] s2_ey_r [NUM_EDGES];
  logic        [EW-1:0] s2_aex_r [NUM_EDGES];
  logic        [EW-1:0] s2_aey_r [NUM_EDGES];
  logic signed [VW-1:0] s2_vx_r [NUM_VERTS];
  logic signed [VW-1:0] s2_vy_r [NUM_VERTS];
  logic signed [HW-1:0] s2_hx_r, s2_hy_r;
  logic                 s2_sep_axis_r;

  always_comb begin
    for (int k = 0; k < NUM_EDGES; k++) begin
      ex_nxt[k]  = EW'(s1_vx_r[NEXT_VERT[k]]) - EW'(s1_vx_r[k]);
      ey_nxt[k]  = EW'(s1_vy_r[NEXT_VERT[k]]) - EW'(s1_vy_r[k]);
      aex_nxt[k] = ex_nxt[k][EW-1] ? EW'(-ex_nxt[k]) : EW'(ex_nxt[k]);
      aey_nxt[k] = ey_nxt[k][EW-1] ? EW'(-ey_nxt[k]) : EW'(ey_nxt[k]);
    end
    // Box axes separate when all three vertices lie beyond one side.
    hx_ext  = VW'(s1_hx_r);
    hy_ext  = VW'(s1_hy_r);
    nhx     = -hx_ext;
    nhy     = -hy_ext;
    above_x = 1'b1;
    below_x = 1'b1;
    above_y = 1'b1;
    below_y = 1'b1;
    for (int i = 0; i < NUM_VERTS; i++) begin
      above_x = above_x && (s1_vx_r[i] > hx_ext);
      below_x = below_x && (s1_vx_r[i] < nhx);
      above_y = above_y && (s1_vy_r[i] > hy_ext);
      below_y = below_y && (s1_vy_r[i] < nhy);
    end
    sep_axis_nxt = above_x || below_x || above_y || below_y;
  end

  always_ff @(posedge clk) begin
    if (en2 && s1_valid_r) begin
      s2_ex_r       <= ex_nxt;
      s2_ey_r       <= ey_nxt;
      s2_aex_r      <= aex_nxt;
      s2_aey_r      <= aey_nxt;
      s2_vx_r       <= s1_vx_r;
      s2_vy_r       <= s1_vy_r;
      s2_hx_r       <= s1_hx_r;
      s2_hy_r       <= s1_hy_r;
      s2_sep_axis_r <= sep_axis_nxt;
    end
  end

  // ---------------------------------------------------------------------
  // Stage 3: projection and radius products for each edge normal.
  // ---------------------------------------------------------------------
  logic signed [MW-1:0] pa1_nxt [NUM_EDGES];
  logic signed [MW-1:0] pa2_nxt [NUM_EDGES];
  logic signed [MW-1:0] pb1_nxt [NUM_EDGES];
  logic signed [MW-1:0] pb2_nxt [NUM_EDGES];
  logic signed [MW-1:0] rx_nxt  [NUM_EDGES];
  logic signed [MW-1:0] ry_nxt  [NUM_EDGES];

  logic signed [MW-1:0] s3_pa1_r [NUM_EDGES];
  logic signed [MW-1:0] s3_pa2_r [NUM_EDGES];
  logic signed [MW-1:0] s3_pb1_r [NUM_EDGES];
  logic signed [MW-1:0] s3_pb2_r [NUM_EDGES];
  logic signed [MW-1:0] s3_rx_r  [NUM_EDGES];
  logic signed [MW-1:0] s3_ry_r  [NUM_EDGES];
  logic                 s3_sep_axis_r;

  always_comb begin
    for (int k = 0; k < NUM_EDGES; k++) begin
      pa1_nxt[k] = MW'(s2_ey_r[k]) * MW'(s2_vx_r[EDGE_PT_A[k]]);
      pa2_nxt[k] = MW'(s2_ex_r[k]) * MW'(s2_vy_r[EDGE_PT_A[k]]);
      pb1_nxt[k] = MW'(s2_ey_r[k]) * MW'(s2_vx_r[EDGE_PT_B[k]]);
      pb2_nxt[k] = MW'(s2_ex_r[k]) * MW'(s2_vy_r[EDGE_PT_B[k]]);
      rx_nxt[k]  = MW'($signed({1'b0, s2_aey_r[k]})) * MW'(s2_hx_r);
      ry_nxt[k]  = MW'($signed({1'b0, s2_aex_r[k]})) * MW'(s2_hy_r);
    end
  end

  always_ff @(posedge clk) begin
    if (en3 && s2_valid_r) begin
      s3_pa1_r      <= pa1_nxt;
      s3_pa2_r      <= pa2_nxt;
      s3_pb1_r      <= pb1_nxt;
      s3_pb2_r      <= pb2_nxt;
      s3_rx_r       <= rx_nxt;
      s3_ry_r       <= ry_nxt;
      s3_sep_axis_r <= s2_sep_axis_r;
    end
  end

  // ---------------------------------------------------------------------
  // Stage 4: projections of both points and the box radius with its negation.
  // ---------------------------------------------------------------------
  logic signed [PW-1:0] proj_a_nxt [NUM_EDGES];
  logic signed [PW-1:0] proj_b_nxt [NUM_EDGES];
  logic signed [PW-1:0] rad_nxt    [NUM_EDGES];
  logic signed [PW-1:0] nrad_nxt   [NUM_EDGES];

  logic signed [PW-1:0] s4_proj_a_r [NUM_EDGES];
  logic signed [PW-1:0] s4_proj_b_r [NUM_EDGES];
  logic signed [PW-1:0] s4_rad_r    [NUM_EDGES];
  logic signed [PW-1:0] s4_nrad_r   [NUM_EDGES];
  logic                 s4_sep_axis_r;

  always_comb begin
    for (int k = 0; k < NUM_EDGES; k++) begin
      proj_a_nxt[k] = PW'(s3_pa1_r[k]) - PW'(s3_pa2_r[k]);
      proj_b_nxt[k] = PW'(s3_pb1_r[k]) - PW'(s3_pb2_r[k]);
      rad_nxt[k]    = PW'(s3_rx_r[k]) + PW'(s3_ry_r[k]);
      nrad_nxt[k]   = -PW'(s3_rx_r[k]) - PW'(s3_ry_r[k]);
    end
  end

  always_ff @(posedge clk) begin
    if (en4 && s3_valid_r) begin
      s4_proj_a_r   <= proj_a_nxt;
      s4_proj_b_r   <= proj_b_nxt;
      s4_rad_r      <= rad_nxt;
      s4_nrad_r     <= nrad_nxt;
      s4_sep_axis_r <= s3_sep_axis_r;
    end
  end

  // ---------------------------------------------------------------------
  // Stage 5: interval tests on the edge normals and the output register.
  // ---------------------------------------------------------------------
  logic sep_edge;
  logic overlap_nxt;
  logic overlap_r;

  always_comb begin
    sep_edge = 1'b0;
    for (int k = 0; k < NUM_EDGES; k++) begin
      // The radius lies below both projections, or both lie below its negation.
      sep_edge = sep_edge
        || ((s4_rad_r[k] < s4_proj_a_r[k]) && (s4_rad_r[k] < s4_proj_b_r[k]))
        || ((s4_proj_a_r[k] < s4_nrad_r[k]) && (s4_proj_b_r[k] < s4_nrad_r[k]));
    end
    overlap_nxt = !(sep_edge || s4_sep_axis_r);
  end

  always_ff @(posedge clk) begin
    if (en_out && s4_valid_r) begin
      overlap_r <= overlap_nxt;
    end
  end

  assign out_if.valid   = out_valid_r;
  assign out_if.overlap = overlap_r;

  // ---------------------------------------------------------------------
  // Assertions.
  // ---------------------------------------------------------------------
  // With no result waiting, every stage can advance, so input is taken.
  a_ready_when_out_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid_r |-> in_if.ready)
    else $error("input not ready while the output register is empty");

  // A valid item in the last stage reaches the output when it advances.
  a_last_stage_moves: assert property (@(posedge clk) disable iff (!rst_n)
    (s4_valid_r && en_out) |=> out_valid_r)
    else $error("item lost between the last stage and the output");

  // A box-axis separation always gives a no-overlap result.
  a_axis_sep_result: assert property (@(posedge clk) disable iff (!rst_n)
    (s4_valid_r && en_out && s4_sep_axis_r) |=> !overlap_r)
    else $error("box-axis separation did not clear the overlap flag");

  // An input transfer always fills the first stage.
  a_first_stage_fill: assert property (@(posedge clk) disable iff (!rst_n)
    (in_if.valid && in_if.ready) |=> s1_valid_r)
    else $error("input transfer did not fill the first stage");

endmodule
